// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk, held off while rst_n is low.
`define WMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check on clk that also runs through reset.
`define WMS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/wms_pkg.sv
package wms_pkg;

  localparam int SCORE_W  = 38;
  localparam int CFG_W    = 7;
  localparam int IDX_W    = 6;
  localparam int SYM_IN_W = 8;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TEXT = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [IDX_W-1:0]    pattern_index;
    logic [SYM_IN_W-1:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               is_match;
  } out_item_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic text_en;
    logic pat_rot;
  } cell_ctl_t;

  // sequencer to term/accumulate unit
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic clear;
  } acc_ctl_t;

endpackage

// File: rtl/wms_cell.sv
module wms_cell #(
  parameter int SYMBOL_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wms_pkg::cell_ctl_t     ctl,
  input  logic                   p_we,
  input  logic [SYMBOL_BITS-1:0] p_wdata,
  input  logic [SYMBOL_BITS-1:0] p_in,
  input  logic [SYMBOL_BITS-1:0] t_in,
  output logic [SYMBOL_BITS-1:0] p_out,
  output logic [SYMBOL_BITS-1:0] t_out
);
  import wms_pkg::*;

  logic [SYMBOL_BITS-1:0] p_r, p_nxt;
  logic [SYMBOL_BITS-1:0] t_r, t_nxt;

  always_comb begin
    priority if (p_we) begin
      p_nxt = p_wdata;
    end else if (ctl.pat_rot) begin
      p_nxt = p_in;
    end else begin
      p_nxt = p_r;
    end
    t_nxt = ctl.text_en ? t_in : t_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= '0;
      t_r <= '0;
    end else begin
      p_r <= p_nxt;
      t_r <= t_nxt;
    end
  end

  assign p_out = p_r;
  assign t_out = t_r;

endmodule

// File: rtl/wms_acc.sv
module wms_acc #(
  parameter int SYMBOL_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wms_pkg::acc_ctl_t           ctl,
  input  logic [SYMBOL_BITS-1:0]      p_sym,
  input  logic [SYMBOL_BITS-1:0]      t_sym,
  output logic [wms_pkg::SCORE_W-1:0] sum,
  output logic                        done
);
  import wms_pkg::*;

  localparam int PW = 2 * SYMBOL_BITS;
  localparam int TW = 4 * SYMBOL_BITS;
  localparam int AW = ((TW > SCORE_W) ? TW : SCORE_W) + 1;

  logic [SYMBOL_BITS-1:0] diff;

  // stage 1: p*t and (p-t)^2
  logic          s1_valid_r, s1_first_r, s1_last_r;
  logic [PW-1:0] s1_pt_r, s1_dd_r;
  // stage 2: full term
  logic          s2_valid_r, s2_first_r, s2_last_r;
  logic [TW-1:0] s2_term_r;
  // stage 3: saturating sum
  logic [SCORE_W-1:0] sum_r, sum_nxt;
  logic               done_r, done_nxt;
  logic [SCORE_W-1:0] base;
  logic [AW-1:0]      wide;

  assign diff = (p_sym >= t_sym) ? (p_sym - t_sym) : (t_sym - p_sym);

  always_comb begin
    base = s2_first_r ? '0 : sum_r;
    wide = AW'(base) + AW'(s2_term_r);
    sum_nxt  = sum_r;
    done_nxt = done_r;
    if (ctl.clear) begin
      done_nxt = 1'b0;
    end
    if (s2_valid_r) begin
      sum_nxt = (wide > AW'(SCORE_MAX)) ? SCORE_MAX : wide[SCORE_W-1:0];
      if (s2_last_r) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_first_r <= 1'b0;
      s1_last_r  <= 1'b0;
      s2_valid_r <= 1'b0;
      s2_first_r <= 1'b0;
      s2_last_r  <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      s1_valid_r <= ctl.valid;
      s1_first_r <= ctl.first;
      s1_last_r  <= ctl.last;
      s2_valid_r <= s1_valid_r;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      done_r     <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_pt_r   <= PW'(p_sym) * PW'(t_sym);
    s1_dd_r   <= PW'(diff) * PW'(diff);
    s2_term_r <= TW'(s1_pt_r) * TW'(s1_dd_r);
    sum_r     <= sum_nxt;
  end

  assign sum  = sum_r;
  assign done = done_r;

endmodule

// File: rtl/wildcard_match_scorer.sv
// Wildcard match scorer. Write pattern symbols with kind = 0 (pattern_index picks the
// slot, symbol 0 is a wildcard), then stream text symbols with kind = 1. Once
// pattern_length text symbols have arrived since the last pattern write, every text item
// returns score = sum over j of p_j*t*(p_j-t)^2 against the latest pattern_length text
// symbols (oldest aligned with p_0), and is_match = 1 when the score is zero. The score is
// exact and saturates at 2^38-1. Pattern writes and unscored text items leave it idle.
// A scored text item holds the input while the text and pattern rows are rotated past a
// single term unit and both end back in place, with terms taken over L, the effective
// pattern length; then a drain waits for the three-stage multiply/accumulate pipe behind
// the last term. For L below MAX_PATTERN-1 the pipe empties during the scan, so the
// drain then waits only on the output register.
// The drain also waits while an earlier score sits untaken in the output register;
// pattern writes and unscored text items pass that register freely. A pattern_length
// of 0 acts as 1, and one above MAX_PATTERN acts as MAX_PATTERN. Write pattern_length
// only while the block is idle.
`include "assert_macros.svh"

module wildcard_match_scorer #(
  parameter int MAX_PATTERN = 64,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // item input
  input  logic                      in_valid,
  output logic                      in_ready,
  input  wms_pkg::in_item_t         in_item,
  // result output
  output logic                      out_valid,
  input  logic                      out_ready,
  output wms_pkg::out_item_t        out_item,
  // pattern_length register
  input  logic                      cfg_we,
  input  logic [wms_pkg::CFG_W-1:0] cfg_wdata
);
  import wms_pkg::*;

  localparam int N  = MAX_PATTERN;
  localparam int LW = $clog2(N + 1);   // fill count and effective length
  localparam int CW = $clog2(2 * N);   // scan pass counter

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN} state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [LW-1:0]   fill_r, fill_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;
  logic [CFG_W-1:0] cfg_r;

  logic [LW-1:0] eff;
  logic [LW-1:0] fill_inc;
  logic          in_acc, load_acc, text_acc, score_go;
  logic          out_free, out_take, out_load;

  // scan window: terms are taken for lo <= cnt < N
  logic [CW-1:0] lo, scan_last;
  logic          text_rot, in_window;

  // cell row
  cell_ctl_t              cell_ctl;
  logic [SYMBOL_BITS-1:0] p_q [N];
  logic [SYMBOL_BITS-1:0] t_q [N];
  logic [SYMBOL_BITS-1:0] sym;
  logic [SYMBOL_BITS-1:0] t_head_in;

  acc_ctl_t           acc_ctl;
  logic [SCORE_W-1:0] acc_sum;
  logic               acc_done;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_W'(1);
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // clamp the length into 1..N
  always_comb begin
    priority if (cfg_r == '0) begin
      eff = LW'(1);
    end else if (32'(cfg_r) > N) begin
      eff = LW'(N);
    end else begin
      eff = LW'(cfg_r);
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_acc = in_acc && (in_item.kind == KIND_LOAD);
  assign text_acc = in_acc && (in_item.kind == KIND_TEXT);
  assign fill_inc = (fill_r < LW'(N)) ? fill_r + LW'(1) : fill_r;
  assign score_go = text_acc && (fill_inc >= eff);

  assign out_take = out_valid_r && out_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r == ST_DRAIN) && acc_done && out_free;

  // Text rotates while cnt runs 0..N-1, so the text head (cell N-1) walks from the
  // oldest symbol to the newest and ends where it started. The pattern rotates from lo =
  // N-L through scan_last, so pattern head (cell 0) shows p_0 exactly when the text head
  // shows the symbol aligned with it, and the pattern row is restored at scan_last.
  assign lo        = CW'(N) - CW'(eff);
  assign scan_last = CW'(2 * N - 1) - CW'(eff);
  assign text_rot  = (state_r == ST_SCAN) && (cnt_r < CW'(N));
  assign in_window = (state_r == ST_SCAN) && (cnt_r >= lo) && (cnt_r < CW'(N));

  assign cell_ctl.text_en = text_acc || text_rot;
  assign cell_ctl.pat_rot = (state_r == ST_SCAN) && (cnt_r >= lo);

  assign sym       = SYMBOL_BITS'(in_item.symbol);
  assign t_head_in = text_acc ? sym : t_q[N-1];

  for (genvar k = 0; k < N; k++) begin : g_cell
    localparam int NEXT = (k + 1) % N;
    logic p_we;
    assign p_we = load_acc && (int'(in_item.pattern_index) == k);
    if (k == 0) begin : g_head
      wms_cell #(.SYMBOL_BITS(SYMBOL_BITS)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (cell_ctl),
        .p_we    (p_we),
        .p_wdata (sym),
        .p_in    (p_q[NEXT]),
        .t_in    (t_head_in),
        .p_out   (p_q[k]),
        .t_out   (t_q[k])
      );
    end else begin : g_body
      wms_cell #(.SYMBOL_BITS(SYMBOL_BITS)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (cell_ctl),
        .p_we    (p_we),
        .p_wdata (sym),
        .p_in    (p_q[NEXT]),
        .t_in    (t_q[k-1]),
        .p_out   (p_q[k]),
        .t_out   (t_q[k])
      );
    end
  end

  assign acc_ctl.valid = in_window;
  assign acc_ctl.first = in_window && (cnt_r == lo);
  assign acc_ctl.last  = in_window && (cnt_r == CW'(N - 1));
  assign acc_ctl.clear = out_load;

  wms_acc #(.SYMBOL_BITS(SYMBOL_BITS)) u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (acc_ctl),
    .p_sym (p_q[0]),
    .t_sym (t_q[N-1]),
    .sum   (acc_sum),
    .done  (acc_done)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      ST_IDLE: begin
        if (load_acc) begin
          fill_nxt = '0;
        end else if (text_acc) begin
          fill_nxt = fill_inc;
          if (score_go) begin
            state_nxt = ST_SCAN;
            cnt_nxt   = '0;
          end
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (out_load) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.score    = acc_sum;
      out_item_nxt.is_match = (acc_sum == '0);
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `WMS_ASSERT(a_load_clears_fill, load_acc |=> (fill_r == '0), "pattern write kept fill count")
  `WMS_ASSERT(a_full_starts_scan, score_go |=> (state_r == ST_SCAN && cnt_r == '0),
              "scored text item did not start a scan")
  `WMS_ASSERT(a_fill_bound, fill_r <= LW'(N), "fill count above window size")
  `WMS_ASSERT(a_result_from_drain, $rose(out_valid_r) |-> $past(state_r == ST_DRAIN),
              "result raised outside drain")
  `WMS_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == ST_IDLE && !out_valid_r),
                  "reset did not clear sequencer")

endmodule
